// ===== hdl/bpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_pkg: shared definitions for the bounded priority queue
// Entry layout, control bundle for the cell row, status and operation codes.
// ----------------------------------------------------------------------------
package bpq_pkg;

    // Number of cells in the row (queue capacity).
    localparam int DEPTH = 16;

    // Width of the entry counter; it must hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the item and result ports.
    localparam int ID_W   = 32;
    localparam int PRIO_W = 4;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Legal priority range; higher values are served first.
    localparam logic [PRIO_W-1:0] PRIO_MIN = PRIO_W'(1);
    localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(10);

    // Operation codes.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // One queue entry as held by a cell.
    typedef struct packed {
        logic signed [ID_W-1:0] id;
        logic [PRIO_W-1:0]      prio;
    } entry_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic   enq_en;
        logic   deq_en;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

// ===== hdl/bpq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_cell: one slot of the sorted queue
// Holds one entry. On an insert it keeps its entry, takes the new entry or
// takes its left neighbor's entry; on a removal it takes its right neighbor's.
// ----------------------------------------------------------------------------
module bpq_cell (
    input  logic                clk,
    input  bpq_pkg::cell_ctrl_t ctrl,
    input  logic                valid,
    input  logic                left_keep,
    input  bpq_pkg::entry_t     left_entry,
    input  bpq_pkg::entry_t     right_entry,
    output bpq_pkg::entry_t     entry,
    output logic                keep
);

    bpq_pkg::entry_t entry_reg;
    bpq_pkg::entry_t entry_next;

    // The entry stays in place when it outranks or ties the incoming one.
    assign keep  = valid && (entry_reg.prio >= ctrl.new_entry.prio);
    assign entry = entry_reg;

    // Select the next content of this slot.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.deq_en)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.enq_en && !keep)
        begin
            if (left_keep)
            begin
                entry_next = ctrl.new_entry;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hdl/bounded_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_priority_queue: sorted scheduler queue on a row of cells
// Enqueue and dequeue of prioritized process ids, highest priority first,
// arrival order among equal priorities.
// ----------------------------------------------------------------------------
// The edge that accepts an item raises busy; in the following cycle every
// cell of the row decides its new content in parallel from its own entry and
// its neighbors, and the status and the removed id are formed from the entry
// counter and the front cell. At the end of that cycle the row updates and the
// result is registered; done then marks the result for exactly one cycle, and
// since busy is already low in that cycle the next item can be accepted
// alongside it. The receiver cannot stall the result, so it must take it in
// the cycle that done is high.
// Entries are not cleared at reset; the counter alone tells which cells hold
// entries.
// ----------------------------------------------------------------------------
module bounded_priority_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic signed [bpq_pkg::ID_W-1:0]     process_id,
    input  logic [bpq_pkg::PRIO_W-1:0]          priority_req,
    output logic                                done,
    output logic signed [bpq_pkg::ID_W-1:0]     result_id,
    output logic [bpq_pkg::STAT_W-1:0]          status,
    output logic [bpq_pkg::OCC_W-1:0]           occupancy
);

    localparam int WIDE_W = (bpq_pkg::CNT_W > bpq_pkg::OCC_W) ?
                            bpq_pkg::CNT_W : bpq_pkg::OCC_W;

    // Control registers.
    logic                        busy_reg;
    logic                        busy_next;
    logic                        done_reg;
    logic                        done_next;
    logic [bpq_pkg::CNT_W-1:0]   count_reg;
    logic [bpq_pkg::CNT_W-1:0]   count_next;

    // Captured item.
    logic                        op_reg;
    bpq_pkg::entry_t             item_reg;

    // Result registers.
    logic signed [bpq_pkg::ID_W-1:0] rid_reg;
    logic signed [bpq_pkg::ID_W-1:0] rid_next;
    bpq_pkg::status_t            stat_reg;
    bpq_pkg::status_t            stat_next;

    // Row signals.
    bpq_pkg::cell_ctrl_t         ctrl;
    logic                        enq_en;
    logic                        deq_en;
    logic                        prio_ok;
    logic                        is_empty;
    logic                        is_full;
    logic                        accept;
    logic [WIDE_W-1:0]           count_wide;
    bpq_pkg::entry_t             cell_entry [bpq_pkg::DEPTH];
    logic [bpq_pkg::DEPTH-1:0]   cell_keep;
    logic [bpq_pkg::DEPTH-1:0]   cell_valid;

    assign accept = start && !busy_reg;

    // Capture the item on acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= operation;
            item_reg.id   <= process_id;
            item_reg.prio <= priority_req;
        end
    end

    // Decode the captured item against the current fill level.
    assign prio_ok  = (item_reg.prio >= bpq_pkg::PRIO_MIN) &&
                      (item_reg.prio <= bpq_pkg::PRIO_MAX);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == bpq_pkg::CNT_W'(bpq_pkg::DEPTH));

    always_comb
    begin
        enq_en     = 1'b0;
        deq_en     = 1'b0;
        stat_next  = bpq_pkg::ST_OK;
        rid_next   = '0;
        count_next = count_reg;
        if (busy_reg)
        begin
            if (op_reg == bpq_pkg::OP_DEQ)
            begin
                if (is_empty)
                begin
                    stat_next = bpq_pkg::ST_EMPTY;
                end
                else
                begin
                    deq_en     = 1'b1;
                    rid_next   = cell_entry[0].id;
                    count_next = count_reg - bpq_pkg::CNT_W'(1);
                end
            end
            else if (!prio_ok)
            begin
                stat_next = bpq_pkg::ST_RANGE;
            end
            else if (is_full)
            begin
                stat_next = bpq_pkg::ST_FULL;
            end
            else
            begin
                enq_en     = 1'b1;
                count_next = count_reg + bpq_pkg::CNT_W'(1);
            end
        end
    end

    // Handshake sequencing: busy registers the acceptance, then done registers busy as the strobe.
    assign busy_next = accept;
    assign done_next = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rid_reg  <= rid_next;
            stat_reg <= stat_next;
        end
    end

    // Broadcast control to the row.
    assign ctrl.enq_en    = enq_en;
    assign ctrl.deq_en    = deq_en;
    assign ctrl.new_entry = item_reg;

    // Row of cells; cell 0 is the front of the queue.
    for (genvar i = 0; i < bpq_pkg::DEPTH; i++)
    begin : g_cell
        assign cell_valid[i] = (bpq_pkg::CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            bpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid       (cell_valid[i]),
                .left_keep   (1'b1),
                .left_entry  (item_reg),
                .right_entry (cell_entry[i+1]),
                .entry       (cell_entry[i]),
                .keep        (cell_keep[i])
            );
        end
        else if (i == bpq_pkg::DEPTH - 1)
        begin : g_last
            bpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid       (cell_valid[i]),
                .left_keep   (cell_keep[i-1]),
                .left_entry  (cell_entry[i-1]),
                .right_entry ('0),
                .entry       (cell_entry[i]),
                .keep        (cell_keep[i])
            );
        end
        else
        begin : g_mid
            bpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid       (cell_valid[i]),
                .left_keep   (cell_keep[i-1]),
                .left_entry  (cell_entry[i-1]),
                .right_entry (cell_entry[i+1]),
                .entry       (cell_entry[i]),
                .keep        (cell_keep[i])
            );
        end
    end

    // Outputs.
    assign count_wide = WIDE_W'(count_reg);
    assign busy       = busy_reg;
    assign done       = done_reg;
    assign result_id  = rid_reg;
    assign status     = stat_reg;
    assign occupancy  = count_wide[bpq_pkg::OCC_W-1:0];

    // Checks.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("work cycle and result strobe overlap");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bpq_pkg::CNT_W'(bpq_pkg::DEPTH))
        else $error("entry count exceeds capacity");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> $stable(count_reg))
        else $error("entry count changed without an item");

    a_ok_moves_count: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (stat_next == bpq_pkg::ST_OK)) |=> (count_reg != $past(count_reg)))
        else $error("successful item left the entry count unchanged");

endmodule
